// ===== src/bts_pkg.sv =====
`default_nettype none
package bts_pkg;

  localparam int DEF_MAX_WIDTH   = 256;
  localparam int DEF_MAX_HEIGHT  = 256;
  localparam int DEF_WEIGHT_BITS = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int TEXEL_W    = 24;
  localparam int INTEN_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_ENABLE = 2'd2;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // floor(65535 * (c/255)^2.2): largest g with g^5 * 255^11 <= c^11 * 65535^5
  function automatic logic [255:0][15:0] gamma_table();
    logic [255:0][15:0] tab;
    logic [191:0] rhs;
    logic [191:0] lhs;
    logic [16:0]  lo;
    logic [16:0]  hi;
    logic [16:0]  mid;
    for (int c = 0; c < 256; c++) begin
      rhs = 192'd1;
      for (int k = 0; k < 11; k++) rhs = rhs * 192'(c);
      for (int k = 0; k < 5; k++) rhs = rhs * 192'd65535;
      lo = 17'd0;
      hi = 17'd65535;
      for (int it = 0; it < 17; it++) begin
        if (lo < hi) begin
          mid = (lo + hi + 17'd1) >> 1;
          lhs = 192'd1;
          for (int k = 0; k < 5; k++) lhs = lhs * 192'(mid);
          for (int k = 0; k < 11; k++) lhs = lhs * 192'd255;
          if (lhs <= rhs) lo = mid;
          else hi = mid - 17'd1;
        end
      end
      tab[c] = lo[15:0];
    end
    return tab;
  endfunction

  localparam logic [255:0][15:0] GAMMA_ROM = gamma_table();

endpackage
`default_nettype wire

// ===== src/bilinear_texture_sampler_unit.sv =====
`default_nettype none
// Bilinear texture sampler with wrap addressing over a stored RGB8 image.
// in_tuser selects a texel write (0) or a sample (1); writes give no result,
// each sample gives one transfer of filtered red, green and blue in Q0.16.
// One item is taken per clock when the output side keeps up; a sample's
// result passes through the front multiply stage, the four-entry queue,
// the texel store read and three filter stages. The store is four copies
// of the image, each with one read port, so the four neighbors are read in
// a single cycle; it has no reset and a texel must be written before it is
// sampled. The user must change registers only while the block is idle;
// the block itself does not enforce this.
module bilinear_texture_sampler_unit #(
  parameter int MAX_WIDTH   = bts_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = bts_pkg::DEF_MAX_HEIGHT,
  parameter int WEIGHT_BITS = bts_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // coord_u, coord_v, texel_x, texel_y, texel_red, texel_green, texel_blue
  input  wire logic [103:0]                   in_tdata,
  // func
  input  wire logic                           in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // red, green, blue
  output logic [47:0]                         out_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bts_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bts_pkg::*;

  localparam int EW = 2 + 4 * $clog2(MAX_WIDTH * MAX_HEIGHT) + 24 + 2 * WEIGHT_BITS;

  logic [CFG_DATA_W-1:0] tex_width_r, tex_height_r;
  logic                  gamma_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= CFG_DATA_W'(256);
      tex_height_r <= CFG_DATA_W'(256);
      gamma_en_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEX_WIDTH:    tex_width_r  <= cfg_wdata;
        CFG_TEX_HEIGHT:   tex_height_r <= cfg_wdata;
        CFG_GAMMA_ENABLE: gamma_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic          q_push, q_full, q_pop, q_empty;
  logic [EW-1:0] q_in, q_out;

  bts_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .WEIGHT_BITS(WEIGHT_BITS), .EW(EW)
  ) u_front (
    .clk, .rst_n,
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .func       (in_tuser),
    .coord_u    (in_tdata[31:0]),
    .coord_v    (in_tdata[63:32]),
    .texel_x    (in_tdata[71:64]),
    .texel_y    (in_tdata[79:72]),
    .texel_rgb  ({in_tdata[87:80], in_tdata[95:88], in_tdata[103:96]}),
    .tex_width  (tex_width_r),
    .tex_height (tex_height_r),
    .q_push, .q_full,
    .q_data     (q_in)
  );

  bts_queue #(.W(EW), .DEPTH(4)) u_queue (
    .clk, .rst_n,
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_out)
  );

  bts_back #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .WEIGHT_BITS(WEIGHT_BITS), .EW(EW)
  ) u_back (
    .clk, .rst_n,
    .q_empty, .q_pop,
    .q_data       (q_out),
    .gamma_enable (gamma_en_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_data     (out_tdata)
  );

endmodule
`default_nettype wire

// ===== src/bts_front.sv =====
`default_nettype none
module bts_front #(
  parameter int MAX_WIDTH   = bts_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = bts_pkg::DEF_MAX_HEIGHT,
  parameter int WEIGHT_BITS = bts_pkg::DEF_WEIGHT_BITS,
  parameter int EW          = 2 + 4 * $clog2(MAX_WIDTH * MAX_HEIGHT) + 24 + 2 * WEIGHT_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            func,
  input  wire logic [31:0]                     coord_u,
  input  wire logic [31:0]                     coord_v,
  input  wire logic [7:0]                      texel_x,
  input  wire logic [7:0]                      texel_y,
  input  wire logic [23:0]                     texel_rgb,
  input  wire logic [bts_pkg::CFG_DATA_W-1:0]  tex_width,
  input  wire logic [bts_pkg::CFG_DATA_W-1:0]  tex_height,
  output logic                                 q_push,
  input  wire logic                            q_full,
  output logic [EW-1:0]                        q_data
);
  import bts_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int IW  = $clog2(MAX_WIDTH);
  localparam int JW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int WB  = WEIGHT_BITS;

  logic [WW-1:0] w;
  logic [HW-1:0] h;

  always_comb begin
    if (tex_width == '0) w = WW'(1);
    else if (32'(tex_width) > MAX_WIDTH) w = WW'(MAX_WIDTH);
    else w = WW'(tex_width);
    if (tex_height == '0) h = HW'(1);
    else if (32'(tex_height) > MAX_HEIGHT) h = HW'(MAX_HEIGHT);
    else h = HW'(tex_height);
  end

  logic             f1_v_r;
  logic             f1_kind_r;
  logic [16+WW-1:0] su_r;
  logic [16+HW-1:0] sv_r;
  logic [WW-1:0]    w_r;
  logic [HW-1:0]    h_r;
  logic [7:0]       x_r;
  logic [7:0]       y_r;
  logic [23:0]      rgb_r;

  assign q_push   = f1_v_r && !q_full;
  assign in_ready = !f1_v_r || !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (in_ready) begin
      f1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f1_kind_r <= func;
      su_r      <= (16+WW)'(coord_u[15:0]) * (16+WW)'(w);
      sv_r      <= (16+HW)'(coord_v[15:0]) * (16+HW)'(h);
      w_r       <= w;
      h_r       <= h;
      x_r       <= texel_x;
      y_r       <= texel_y;
      rgb_r     <= texel_rgb;
    end
  end

  logic [IW-1:0] i, i1;
  logic [JW-1:0] j, j1;
  logic [WB-1:0] wi, wj;
  logic [AW-1:0] a0, a1, a2, a3;
  logic          wen;

  always_comb begin
    i  = su_r[16 +: IW];
    j  = sv_r[16 +: JW];
    wi = su_r[15 -: WB];
    wj = sv_r[15 -: WB];
    i1 = (32'(i) + 1 >= 32'(w_r)) ? '0 : IW'(32'(i) + 1);
    j1 = (32'(j) + 1 >= 32'(h_r)) ? '0 : JW'(32'(j) + 1);
    wen = (32'(x_r) < MAX_WIDTH) && (32'(y_r) < MAX_HEIGHT);
    if (f1_kind_r == FUNC_WRITE) begin
      a0 = AW'(32'(y_r) * MAX_WIDTH + 32'(x_r));
    end else begin
      a0 = AW'(32'(j) * MAX_WIDTH + 32'(i));
    end
    a1 = AW'(32'(j) * MAX_WIDTH + 32'(i1));
    a2 = AW'(32'(j1) * MAX_WIDTH + 32'(i));
    a3 = AW'(32'(j1) * MAX_WIDTH + 32'(i1));
  end

  assign q_data = {f1_kind_r, wen, a3, a2, a1, a0, rgb_r, wj, wi};

endmodule
`default_nettype wire

// ===== src/bts_queue.sv =====
`default_nettype none
module bts_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              empty,
  output logic [W-1:0]      pop_data
);
  localparam int PW = $clog2(DEPTH);

  logic [W-1:0]  q_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full     = (32'(cnt_r) == DEPTH);
  assign empty    = (cnt_r == '0);
  assign pop_data = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (32'(wp_r) == DEPTH - 1) ? '0 : wp_r + PW'(1);
      if (pop) rp_r <= (32'(rp_r) == DEPTH - 1) ? '0 : rp_r + PW'(1);
      if (push && !pop) cnt_r <= cnt_r + (PW+1)'(1);
      else if (pop && !push) cnt_r <= cnt_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_data;
  end

endmodule
`default_nettype wire

// ===== src/bts_back.sv =====
`default_nettype none
module bts_back #(
  parameter int MAX_WIDTH   = bts_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = bts_pkg::DEF_MAX_HEIGHT,
  parameter int WEIGHT_BITS = bts_pkg::DEF_WEIGHT_BITS,
  parameter int EW          = 2 + 4 * $clog2(MAX_WIDTH * MAX_HEIGHT) + 24 + 2 * WEIGHT_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  output logic               q_pop,
  input  wire logic [EW-1:0] q_data,
  input  wire logic          gamma_enable,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [47:0]        out_data
);
  import bts_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int WB  = WEIGHT_BITS;
  localparam int WTW = 2 * WB + 1;
  localparam int PRW = INTEN_W + WTW;
  localparam int SW  = PRW + 2;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  logic          e_kind, e_wen;
  logic [AW-1:0] e_a [4];
  logic [23:0]   e_rgb;
  logic [WB-1:0] e_wi, e_wj;

  assign {e_kind, e_wen, e_a[3], e_a[2], e_a[1], e_a[0], e_rgb, e_wj, e_wi} = q_data;

  logic adv;
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && !q_empty;

  // stage 0: four copies of the store, one read port each
  logic          b0_v_r;
  logic [23:0]   t_r [4];
  logic [WB-1:0] wi0_r, wj0_r;

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [23:0] mem [DEPTH];
    always_ff @(posedge clk) begin
      if (q_pop && e_kind == FUNC_WRITE && e_wen) mem[e_a[0]] <= e_rgb;
      if (q_pop && e_kind == FUNC_SAMPLE) t_r[k] <= mem[e_a[k]];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wi0_r <= e_wi;
      wj0_r <= e_wj;
    end
  end

  // stage 1: intensity conversion and weights
  logic               b1_v_r;
  logic [INTEN_W-1:0] c1_r [3][4];
  logic [WTW-1:0]     wt1_r [4];
  logic [WB:0]        omi, omj;
  logic [7:0]         byt [3][4];

  always_comb begin
    omi = (WB+1)'(1) << WB;
    omj = omi - (WB+1)'(wj0_r);
    omi = omi - (WB+1)'(wi0_r);
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 4; k++) byt[ch][k] = t_r[k][23 - 8 * ch -: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int k = 0; k < 4; k++) begin
          c1_r[ch][k] <= gamma_enable ? GAMMA_ROM[byt[ch][k]] : {byt[ch][k], byt[ch][k]};
        end
      end
      wt1_r[0] <= WTW'(omi) * WTW'(omj);
      wt1_r[1] <= WTW'(wi0_r) * WTW'(omj);
      wt1_r[2] <= WTW'(omi) * WTW'(wj0_r);
      wt1_r[3] <= WTW'(wi0_r) * WTW'(wj0_r);
    end
  end

  // stage 2: weighted products
  logic           b2_v_r;
  logic [PRW-1:0] p2_r [3][4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int k = 0; k < 4; k++) p2_r[ch][k] <= PRW'(c1_r[ch][k]) * PRW'(wt1_r[k]);
      end
    end
  end

  // stage 3: sum, scale, saturate into the output register
  logic          out_v_r;
  logic [47:0]   out_d_r;
  logic [SW-1:0] sum [3];
  logic [SW-2*WB-1:0] sh [3];
  logic [47:0]   out_d_nxt;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = SW'(p2_r[ch][0]) + SW'(p2_r[ch][1]) + SW'(p2_r[ch][2]) + SW'(p2_r[ch][3]);
      sh[ch]  = sum[ch][SW-1:2*WB];
      out_d_nxt[16*ch +: 16] = (sh[ch] > (SW-2*WB)'(16'hFFFF)) ? 16'hFFFF : sh[ch][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r  <= 1'b0;
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      b0_v_r  <= q_pop && e_kind == FUNC_SAMPLE;
      b1_v_r  <= b0_v_r;
      b2_v_r  <= b1_v_r;
      out_v_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_d_r <= out_d_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule
`default_nettype wire

// ===== src/bts_checker.sv =====
`default_nettype none
module bts_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);

  // result pending holds until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // pipeline depth: out_tvalid stays low after reset until a sample has had time to pass
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid ##1 !out_tvalid ##1 !out_tvalid ##1 !out_tvalid ##1 !out_tvalid)
    else $error("result appeared too early after reset");

  // a fresh result needs reset to have been released long enough for a sample to pass
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(!rst_n, 1) && !$past(!rst_n, 2) && !$past(!rst_n, 3)
      && !$past(!rst_n, 4))
    else $error("result without time for a sample to pass");

endmodule

bind bilinear_texture_sampler_unit bts_checker u_bts_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);
`default_nettype wire
